// ----- rtl/rast_pkg.sv -----
// Shared constants and codes for the range add / range sum tree.
package rast_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int DATA_W           = 64;
    localparam int VAL_W            = 32;
    localparam int FIELD_IDX_W      = 10;
    localparam int SIZE_W           = 11;
    localparam int RESET_SIZE       = 1024;
    localparam int IN_TDATA_W       = 56;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_SUM = 1'b1;

endpackage

// ----- rtl/rast_node_mem.sv -----
// Node storage: node totals and pending per-element adds, with registered reads.
module rast_node_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_sum_we,
    input  logic [AW-1:0]               i_sum_wa,
    input  logic [rast_pkg::DATA_W-1:0] i_sum_wd,
    input  logic [AW-1:0]               i_sum_ra,
    output logic [rast_pkg::DATA_W-1:0] o_sum_rd,
    input  logic                        i_pend_we,
    input  logic [AW-1:0]               i_pend_wa,
    input  logic [rast_pkg::DATA_W-1:0] i_pend_wd,
    input  logic [AW-1:0]               i_pend_ra,
    output logic [rast_pkg::DATA_W-1:0] o_pend_rd
);
    import rast_pkg::*;

    logic [DATA_W-1:0] r_sum_mem  [DEPTH];
    logic [DATA_W-1:0] r_pend_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_sum_we) begin
            r_sum_mem[i_sum_wa] <= i_sum_wd;
        end
        o_sum_rd <= r_sum_mem[i_sum_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_pend_we) begin
            r_pend_mem[i_pend_wa] <= i_pend_wd;
        end
        o_pend_rd <= r_pend_mem[i_pend_ra];
    end

endmodule

// ----- rtl/rast_mul.sv -----
// Three-stage multiplier of a 64-bit word by a segment length, modulo 2^64.
module rast_mul #(
    parameter int LEN_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rast_pkg::DATA_W-1:0] i_a,
    input  logic [LEN_W-1:0]            i_len,
    output logic                        o_done,
    output logic [rast_pkg::DATA_W-1:0] o_prod
);
    import rast_pkg::*;

    localparam int P_W = VAL_W + LEN_W;

    logic [P_W-1:0]   r_plo;
    logic [P_W-1:0]   r_plo2;
    logic [P_W-1:0]   r_phi;
    logic [VAL_W-1:0] r_ahi;
    logic [LEN_W-1:0] r_len;
    logic             r_v1;
    logic             r_v2;

    // Low half first, high half next, then the two partial products are joined.
    always_ff @(posedge i_clk) begin
        r_plo  <= P_W'(i_a[VAL_W-1:0]) * P_W'(i_len);
        r_ahi  <= i_a[DATA_W-1:VAL_W];
        r_len  <= i_len;
        r_phi  <= P_W'(r_ahi) * P_W'(r_len);
        r_plo2 <= r_plo;
        o_prod <= DATA_W'(r_plo2) + {r_phi[VAL_W-1:0], {VAL_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            o_done <= r_v2;
        end
    end

endmodule

// ----- rtl/range_add_range_sum_tree.sv -----
// Top level: lazy segment tree with range add and range sum over node memories.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: kind; tdata: lo_index, hi_index, add_value
//  m_axis    out        tdata: range_total (sum beats only)
//  cfg       in         i_cfg_data: size_in_use, written when i_cfg_we is high
//
// The tree is walked depth first with a small stack of parent frames. A node that
// misses the range only returns, a covering node takes one memory read and a
// three-stage split multiply, and a partial node descends to both children; for
// an add it then does the child reads and the multiplied write-back.
// After reset a clearing pass over all 4*MAX_ELEMENTS nodes zeroes both memories
// before the first beat is taken. A finished sum waits in the output register
// while the next beat is accepted; the walk stalls at its end only if that
// register is still full and m_axis_tready is low.
module range_add_range_sum_tree #(
    parameter int MAX_ELEMENTS = rast_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: lo_index[9:0], hi_index[19:10], add_value[51:20], zero pad.
    input  logic [rast_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // Field: kind (0 = add, 1 = sum).
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Field: range_total[63:0].
    output logic [rast_pkg::DATA_W-1:0]     m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [rast_pkg::SIZE_W-1:0]     i_cfg_data
);
    import rast_pkg::*;

    localparam int IDX_W      = $clog2(MAX_ELEMENTS);
    localparam int SZ_W       = IDX_W + 1;
    localparam int NODE_COUNT = 4 * MAX_ELEMENTS;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int DEPTH      = IDX_W + 1;
    localparam int SP_W       = $clog2(DEPTH + 1);
    localparam int SPI_W      = $clog2(DEPTH);
    localparam int RST_SIZE   = (MAX_ELEMENTS > RESET_SIZE) ? RESET_SIZE : MAX_ELEMENTS;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_VISIT   = 4'd2;
    localparam logic [3:0] S_COV_RD  = 4'd3;
    localparam logic [3:0] S_COV_MUL = 4'd4;
    localparam logic [3:0] S_PASS_RD = 4'd5;
    localparam logic [3:0] S_RETURN  = 4'd6;
    localparam logic [3:0] S_RESUME  = 4'd7;
    localparam logic [3:0] S_FIX_RD1 = 4'd8;
    localparam logic [3:0] S_FIX_RD2 = 4'd9;
    localparam logic [3:0] S_FIX_MUL = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    typedef struct packed {
        logic [NODE_W-1:0] n;
        logic [IDX_W-1:0]  b;
        logic [IDX_W-1:0]  e;
        logic [DATA_W-1:0] c;
        logic              ph;
    } t_frame;

    logic [3:0]             r_state;
    logic [SZ_W-1:0]        r_size;
    logic                   r_kind;
    logic [FIELD_IDX_W-1:0] r_lo;
    logic [FIELD_IDX_W-1:0] r_hi;
    logic [VAL_W-1:0]       r_v;
    logic [DATA_W-1:0]      r_acc;
    logic [DATA_W-1:0]      r_tmp;
    logic [DATA_W-1:0]      r_p;
    t_frame                 r_cur;
    t_frame                 r_stk [DEPTH];
    logic [SP_W-1:0]        r_sp;
    logic [NODE_W-1:0]      r_clr;
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_data;

    logic [DATA_W-1:0]      sum_rd;
    logic [DATA_W-1:0]      pend_rd;
    logic [NODE_W-1:0]      sum_ra;
    logic                   sum_we;
    logic [NODE_W-1:0]      wr_addr;
    logic [DATA_W-1:0]      sum_wd;
    logic                   pend_we;
    logic [DATA_W-1:0]      pend_wd;
    logic                   mul_start;
    logic [DATA_W-1:0]      mul_a;
    logic                   mul_done;
    logic [DATA_W-1:0]      mul_prod;

    logic [DATA_W-1:0]      v_ext;
    logic                   disjoint;
    logic                   covered;
    logic [IDX_W:0]         be_sum;
    logic [IDX_W-1:0]       mid;
    logic [SZ_W-1:0]        seg_len;
    logic [NODE_W-1:0]      lft;
    logic [NODE_W-1:0]      rgt;
    logic [DATA_W-1:0]      pass;
    logic [SP_W-1:0]        sp_m1;
    logic [SPI_W-1:0]       push_idx;
    logic [SPI_W-1:0]       pop_idx;
    logic                   in_beat;
    logic                   out_load;

    // Geometry of the node under the walk.
    always_comb begin
        v_ext    = {{(DATA_W - VAL_W){r_v[VAL_W-1]}}, r_v};
        disjoint = (32'(r_lo) > 32'(r_cur.e)) || (32'(r_hi) < 32'(r_cur.b));
        covered  = (32'(r_cur.b) >= 32'(r_lo)) && (32'(r_cur.e) <= 32'(r_hi));
        be_sum   = {1'b0, r_cur.b} + {1'b0, r_cur.e};
        mid      = be_sum[IDX_W:1];
        seg_len  = SZ_W'(r_cur.e) - SZ_W'(r_cur.b) + SZ_W'(1);
        lft      = {r_cur.n[NODE_W-2:0], 1'b1};
        rgt      = lft + NODE_W'(1);
        pass     = r_cur.c + pend_rd;
        sp_m1    = r_sp - SP_W'(1);
        push_idx = r_sp[SPI_W-1:0];
        pop_idx  = sp_m1[SPI_W-1:0];
        in_beat  = s_axis_tvalid && s_axis_tready;
        // A finished sum moves into the output register once that register is free or is being read out.
        out_load = (r_state == S_DONE) && (r_kind == KIND_SUM)
                && (!r_out_valid || m_axis_tready);
    end

    // Memory and multiplier control.
    always_comb begin
        unique case (r_state)
            S_RESUME:  sum_ra = lft;
            S_FIX_RD1: sum_ra = rgt;
            default:   sum_ra = r_cur.n;
        endcase
        sum_we    = (r_state == S_CLEAR)
                 || (r_state == S_COV_MUL && mul_done && r_kind == KIND_ADD)
                 || (r_state == S_FIX_MUL && mul_done);
        pend_we   = (r_state == S_CLEAR)
                 || (r_state == S_COV_MUL && mul_done && r_kind == KIND_ADD);
        wr_addr   = (r_state == S_CLEAR) ? r_clr : r_cur.n;
        sum_wd    = (r_state == S_CLEAR) ? '0 : r_tmp + mul_prod;
        pend_wd   = (r_state == S_CLEAR) ? '0 : r_p + v_ext;
        mul_start = (r_state == S_VISIT && !disjoint && covered) || (r_state == S_FIX_RD1);
        if (r_state == S_FIX_RD1) begin
            mul_a = pend_rd;
        end else if (r_kind == KIND_SUM) begin
            mul_a = r_cur.c;
        end else begin
            mul_a = v_ext;
        end
    end

    rast_node_mem #(
        .DEPTH (NODE_COUNT),
        .AW    (NODE_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_sum_we  (sum_we),
        .i_sum_wa  (wr_addr),
        .i_sum_wd  (sum_wd),
        .i_sum_ra  (sum_ra),
        .o_sum_rd  (sum_rd),
        .i_pend_we (pend_we),
        .i_pend_wa (wr_addr),
        .i_pend_wd (pend_wd),
        .i_pend_ra (r_cur.n),
        .o_pend_rd (pend_rd)
    );

    rast_mul #(
        .LEN_W (SZ_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_len   (seg_len),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Size register: zero reads as one, anything above the tree's capacity is clamped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SZ_W'(RST_SIZE);
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_size <= SZ_W'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_ELEMENTS)) begin
                r_size <= SZ_W'(MAX_ELEMENTS);
            end else begin
                r_size <= SZ_W'(i_cfg_data);
            end
        end
    end

    // Walk sequencer. Partial nodes push their frame and descend left, then right;
    // an add rebuilds the node total from both children once the right one returns.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_acc;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + NODE_W'(1);
                    if (r_clr == NODE_W'(NODE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_beat) begin
                        r_kind  <= s_axis_tuser;
                        r_lo    <= s_axis_tdata[FIELD_IDX_W-1:0];
                        r_hi    <= s_axis_tdata[2*FIELD_IDX_W-1:FIELD_IDX_W];
                        r_v     <= s_axis_tdata[2*FIELD_IDX_W+VAL_W-1:2*FIELD_IDX_W];
                        r_cur   <= '{n: '0, b: '0, e: IDX_W'(r_size - SZ_W'(1)),
                                     c: '0, ph: 1'b0};
                        r_sp    <= '0;
                        r_acc   <= '0;
                        r_state <= S_VISIT;
                    end
                end
                S_VISIT: begin
                    if (disjoint) begin
                        r_state <= S_RETURN;
                    end else if (covered) begin
                        r_state <= S_COV_RD;
                    end else if (r_kind == KIND_SUM) begin
                        r_state <= S_PASS_RD;
                    end else begin
                        r_stk[push_idx] <= '{n: r_cur.n, b: r_cur.b, e: r_cur.e,
                                             c: r_cur.c, ph: 1'b0};
                        r_cur   <= '{n: lft, b: r_cur.b, e: mid, c: r_cur.c, ph: 1'b0};
                        r_sp    <= r_sp + SP_W'(1);
                        r_state <= S_VISIT;
                    end
                end
                S_COV_RD: begin
                    r_tmp   <= sum_rd;
                    r_p     <= pend_rd;
                    r_state <= S_COV_MUL;
                end
                S_COV_MUL: begin
                    if (mul_done) begin
                        if (r_kind == KIND_SUM) begin
                            r_acc <= r_acc + r_tmp + mul_prod;
                        end
                        r_state <= S_RETURN;
                    end
                end
                S_PASS_RD: begin
                    // Sums carry the pending amounts of the nodes they pass through.
                    r_stk[push_idx] <= '{n: r_cur.n, b: r_cur.b, e: r_cur.e,
                                         c: pass, ph: 1'b0};
                    r_cur   <= '{n: lft, b: r_cur.b, e: mid, c: pass, ph: 1'b0};
                    r_sp    <= r_sp + SP_W'(1);
                    r_state <= S_VISIT;
                end
                S_RETURN: begin
                    if (r_sp == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cur   <= r_stk[pop_idx];
                        r_sp    <= sp_m1;
                        r_state <= S_RESUME;
                    end
                end
                S_RESUME: begin
                    if (!r_cur.ph) begin
                        r_stk[push_idx] <= '{n: r_cur.n, b: r_cur.b, e: r_cur.e,
                                             c: r_cur.c, ph: 1'b1};
                        r_cur   <= '{n: rgt, b: mid + IDX_W'(1), e: r_cur.e,
                                     c: r_cur.c, ph: 1'b0};
                        r_sp    <= r_sp + SP_W'(1);
                        r_state <= S_VISIT;
                    end else if (r_kind == KIND_SUM) begin
                        r_state <= S_RETURN;
                    end else begin
                        r_state <= S_FIX_RD1;
                    end
                end
                S_FIX_RD1: begin
                    r_tmp   <= sum_rd;
                    r_state <= S_FIX_RD2;
                end
                S_FIX_RD2: begin
                    r_tmp   <= r_tmp + sum_rd;
                    r_state <= S_FIX_MUL;
                end
                S_FIX_MUL: begin
                    if (mul_done) begin
                        r_state <= S_RETURN;
                    end
                end
                S_DONE: begin
                    if (r_kind == KIND_ADD) begin
                        r_state <= S_IDLE;
                    end else if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The multiplier result only ever lands while the walk waits for it.
    a_mul_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_COV_MUL || r_state == S_FIX_MUL))
        else $error("multiplier result arrived outside a wait state");

    // The parent stack never grows past the tree height.
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sp) <= 32'(DEPTH))
        else $error("parent stack overflow");

    // An accepted beat starts a fresh walk at the root with an empty stack.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_VISIT && r_sp == '0 && r_cur.n == '0))
        else $error("walk did not start at the root");

endmodule
